>>> hdl/ppd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants of the indexed-color picture decoder.
// -----------------------------------------------------------------------------
package ppd_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int QUEUE_DEPTH_DEFAULT   = 4;
   localparam int CSR_DATA_WIDTH        = 15;
   localparam int CSR_INDEX_WIDTH       = 2;

   // item kinds
   localparam logic [1:0] KIND_PALETTE = 2'd0;
   localparam logic [1:0] KIND_PIXEL   = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_BYTES    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_HEIGHT = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  palette_index;
      logic [15:0] red_word;
      logic [15:0] green_word;
      logic [15:0] blue_word;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [29:0] pixel_address;
      logic [7:0]  run_length;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        image_done;
   } rsp_payload_type;

   // command from the front end to the palette back end
   typedef struct packed {
      logic        is_write;
      logic [7:0]  index;
      logic [23:0] color;
      logic [29:0] address;
      logic [7:0]  run_length;
      logic        image_done;
   } cmd_type;

endpackage
`default_nettype wire

>>> hdl/ppd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ppd_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module ppd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> hdl/ppd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ppd_front
// Byte parser: row counts, PackBits headers, position tracking; emits
// palette-write and pixel-lookup commands.
// -----------------------------------------------------------------------------
module ppd_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write_enable,
   input  wire logic [ppd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [ppd_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   input  wire logic                                    accept,
   input  wire ppd_pkg::req_payload_type                req_payload,
   output logic                                         cmd_push,
   output ppd_pkg::cmd_type                             cmd
);
   import ppd_pkg::*;

   typedef enum logic [4:0] {
      PH_COUNT     = 5'b00001,
      PH_COUNT_LOW = 5'b00010,
      PH_HEADER    = 5'b00100,
      PH_LITERAL   = 5'b01000,
      PH_REPEAT    = 5'b10000
   } phase_type;

   logic [14:0] row_bytes_ff, image_width_ff, image_height_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  literal_left_ff, literal_left_in;
   logic [15:0] row_bytes_left_ff, row_bytes_left_in;
   logic [7:0]  count_high_ff, count_high_in;
   logic [14:0] row_number_ff, row_number_in;
   logic [15:0] column_ff, column_in;
   logic [29:0] row_base_ff, row_base_in;
   logic [7:0]  repeat_length_ff, repeat_length_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff    <= '0;
         image_width_ff  <= '0;
         image_height_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_ROW_BYTES:    row_bytes_ff    <= csr_write_data;
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
            REG_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [15:0] col_inc;
      logic        do_emit;
      logic        row_end;
      logic        check_end;
      logic [7:0]  emit_len;

      b         = req_payload.data_byte;
      col_inc   = column_ff + 16'd1;
      do_emit   = 1'b0;
      row_end   = 1'b0;
      check_end = 1'b0;
      emit_len  = 8'd1;

      phase_in          = phase_ff;
      literal_left_in   = literal_left_ff;
      row_bytes_left_in = row_bytes_left_ff;
      count_high_in     = count_high_ff;
      row_number_in     = row_number_ff;
      column_in         = column_ff;
      row_base_in       = row_base_ff;
      repeat_length_in  = repeat_length_ff;

      cmd_push = 1'b0;
      cmd      = '0;
      cmd.index   = req_payload.palette_index;
      cmd.color   = {req_payload.red_word[15:8], req_payload.green_word[15:8],
                     req_payload.blue_word[15:8]};
      cmd.address = row_base_ff + {14'd0, column_ff};

      if (accept) begin
         case (req_payload.kind)
            KIND_PALETTE: begin
               cmd_push     = 1'b1;
               cmd.is_write = 1'b1;
            end
            KIND_RESTART: begin
               phase_in          = PH_COUNT;
               literal_left_in   = '0;
               row_bytes_left_in = '0;
               count_high_in     = '0;
               row_number_in     = '0;
               column_in         = '0;
               row_base_in       = '0;
               repeat_length_in  = '0;
            end
            KIND_PIXEL: begin
               // the picture byte itself is the palette index
               cmd.index = b;
               if (row_number_ff < image_height_ff) begin
                  if (row_bytes_ff < 15'd8) begin
                     // unpacked: one byte per pixel, wrap at image width
                     if (image_width_ff != '0) begin
                        do_emit   = 1'b1;
                        column_in = col_inc;
                        if (col_inc >= {1'b0, image_width_ff}) begin
                           row_end = 1'b1;
                        end
                     end
                  end else begin
                     case (phase_ff)
                        PH_COUNT, PH_COUNT_LOW: begin
                           if (phase_ff == PH_COUNT && row_bytes_ff > 15'd250) begin
                              count_high_in = b;
                              phase_in      = PH_COUNT_LOW;
                           end else begin
                              row_bytes_left_in = (phase_ff == PH_COUNT_LOW) ?
                                                  {count_high_ff, b} : {8'd0, b};
                              column_in = '0;
                              if (row_bytes_left_in == '0) begin
                                 row_end = 1'b1;
                              end else begin
                                 phase_in = PH_HEADER;
                              end
                           end
                        end
                        PH_HEADER: begin
                           row_bytes_left_in = row_bytes_left_ff - 16'd1;
                           check_end         = 1'b1;
                           if (b < 8'd128) begin
                              literal_left_in = b + 8'd1;
                              phase_in        = PH_LITERAL;
                           end else if (b > 8'd128) begin
                              // 257 - b, modulo 256
                              repeat_length_in = 8'd1 - b;
                              phase_in         = PH_REPEAT;
                           end
                        end
                        PH_LITERAL: begin
                           row_bytes_left_in = row_bytes_left_ff - 16'd1;
                           check_end         = 1'b1;
                           do_emit           = 1'b1;
                           column_in         = col_inc;
                           literal_left_in   = literal_left_ff - 8'd1;
                           if (literal_left_in == '0) begin
                              phase_in = PH_HEADER;
                           end
                        end
                        default: begin
                           row_bytes_left_in = row_bytes_left_ff - 16'd1;
                           check_end         = 1'b1;
                           do_emit           = 1'b1;
                           emit_len          = repeat_length_ff;
                           column_in         = column_ff + {8'd0, repeat_length_ff};
                           phase_in          = PH_HEADER;
                        end
                     endcase
                     if (check_end && row_bytes_left_in == '0) begin
                        row_end = 1'b1;
                     end
                  end

                  if (row_end) begin
                     row_number_in = row_number_ff + 15'd1;
                     row_base_in   = row_base_ff + {15'd0, row_bytes_ff};
                     column_in     = '0;
                     phase_in      = PH_COUNT;
                  end

                  cmd_push       = do_emit;
                  cmd.run_length = emit_len;
                  cmd.image_done = do_emit && row_end && (row_number_in >= image_height_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_COUNT;
         literal_left_ff   <= '0;
         row_bytes_left_ff <= '0;
         count_high_ff     <= '0;
         row_number_ff     <= '0;
         column_ff         <= '0;
         row_base_ff       <= '0;
         repeat_length_ff  <= '0;
      end else begin
         phase_ff          <= phase_in;
         literal_left_ff   <= literal_left_in;
         row_bytes_left_ff <= row_bytes_left_in;
         count_high_ff     <= count_high_in;
         row_number_ff     <= row_number_in;
         column_ff         <= column_in;
         row_base_ff       <= row_base_in;
         repeat_length_ff  <= repeat_length_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/ppd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ppd_queue
// Small command FIFO between the parser and the palette back end.
// -----------------------------------------------------------------------------
module ppd_queue #(
   parameter int DEPTH = ppd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ppd_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output ppd_pkg::cmd_type      pop_data,
   output logic                  empty
);
   import ppd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/ppd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ppd_back
// Palette store and lookup: applies palette writes in order, reads colors
// for pixel commands and drives the result register.
// -----------------------------------------------------------------------------
module ppd_back #(
   parameter int PALETTE_DEPTH = ppd_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cmd_empty,
   input  wire ppd_pkg::cmd_type         cmd_data,
   output logic                          cmd_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output ppd_pkg::rsp_payload_type      rsp_payload
);
   import ppd_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);

   // entry written since reset; unwritten entries read black
   logic [PALETTE_DEPTH-1:0] written_ff, written_in;

   logic          s1_valid_ff, s1_valid_in;
   logic [29:0]   s1_address_ff;
   logic [7:0]    s1_run_length_ff;
   logic          s1_image_done_ff;
   logic          s1_black_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   logic          in_range;
   logic [AW-1:0] addr;
   logic          out_advance;
   logic          s1_move;
   logic          s1_free;
   logic          wr_en;
   logic          rd_en;
   logic [23:0]   rd_data;

   assign in_range    = (32'(cmd_data.index) < PALETTE_DEPTH);
   assign addr        = cmd_data.index[AW-1:0];
   assign out_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_move     = s1_valid_ff && out_advance;
   assign s1_free     = !s1_valid_ff || out_advance;
   assign cmd_pop     = !cmd_empty && (cmd_data.is_write || s1_free);
   assign wr_en       = cmd_pop && cmd_data.is_write && in_range;
   assign rd_en       = cmd_pop && !cmd_data.is_write;

   ppd_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (cmd_data.color),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[addr] = 1'b1;
      end
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = out_advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         written_ff   <= written_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_address_ff    <= cmd_data.address;
         s1_run_length_ff <= cmd_data.run_length;
         s1_image_done_ff <= cmd_data.image_done;
         s1_black_ff      <= !(in_range && written_ff[addr]);
      end
      if (s1_move) begin
         rsp_payload_ff.pixel_address <= s1_address_ff;
         rsp_payload_ff.run_length    <= s1_run_length_ff;
         {rsp_payload_ff.red, rsp_payload_ff.green, rsp_payload_ff.blue}
            <= s1_black_ff ? 24'd0 : rd_data;
         rsp_payload_ff.image_done    <= s1_image_done_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

>>> hdl/packbits_palette_pixel_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// packbits_palette_pixel_decoder
// Path: a pixel-producing byte passes the command queue, then the palette
//   RAM read with the stage-1 registers, then the result register.
// Throughput: one item per cycle; req_stall rises only when the command
//   queue is full, which follows a stalled result side.
// Reset: clears parser state, registers and the command queue; palette
//   entries read black until written, tracked by per-entry flags, so no clearing pass.
// -----------------------------------------------------------------------------
module packbits_palette_pixel_decoder #(
   parameter int PALETTE_DEPTH = ppd_pkg::PALETTE_DEPTH_DEFAULT,
   parameter int QUEUE_DEPTH   = ppd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [ppd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ppd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ppd_pkg::req_payload_type            req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ppd_pkg::rsp_payload_type                 rsp_payload
);
   import ppd_pkg::*;

   logic    accept;
   logic    cmd_push;
   cmd_type cmd_in;
   cmd_type cmd_head;
   logic    queue_full;
   logic    queue_empty;
   logic    cmd_pop;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   ppd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_payload      (req_payload),
      .cmd_push         (cmd_push),
      .cmd              (cmd_in)
   );

   ppd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (queue_empty)
   );

   ppd_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (queue_empty),
      .cmd_data    (cmd_head),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // every result covers at least one pixel
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.run_length != 8'd0)
      else $error("result with zero run length");

   // queue occupancy flags are exclusive
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(queue_empty && queue_full))
      else $error("command queue both empty and full");

   // nothing pops from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !queue_empty)
      else $error("command popped from empty queue");

   // no result is presented right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire
